### hdl/wtel_pkg.sv
// shared types, constants and the crc step for the wind telemetry framer
package wtel_pkg;

  localparam int SAMPLES_PER_FRAME = 5;
  localparam int SLOT_W            = $clog2(SAMPLES_PER_FRAME);
  localparam int HDR_LEN           = 3;
  localparam int FRAME_LEN         = SAMPLES_PER_FRAME + HDR_LEN + 1;
  localparam int IDX_W             = $clog2(FRAME_LEN);
  localparam int REPLY_LEN         = 9;
  localparam int MATCH_W           = 4;
  localparam logic [7:0] ERROR_LIMIT_RST = 8'd24;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PULSE = 2'd1,
    OP_RX    = 2'd2,
    OP_RING  = 2'd3
  } op_t;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_RESET = 1'b1
  } kind_t;

  // frame byte slots: the header before the direction samples, the crc last
  localparam logic [IDX_W-1:0] IDX_UP_HI = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_UP_LO = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_PULSE = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_CRC   = IDX_W'(FRAME_LEN - 1);

  function automatic logic [7:0] reply_byte(input logic [MATCH_W-1:0] pos);
    logic [7:0] b;
    case (pos)
      4'd0:    b = 8'h0D;
      4'd1:    b = 8'h0A;
      4'd2:    b = 8'h53;
      4'd3:    b = 8'h45;
      4'd4:    b = 8'h4E;
      4'd5:    b = 8'h44;
      4'd6:    b = 8'h20;
      4'd7:    b = 8'h4F;
      4'd8:    b = 8'h4B;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] crc_term(input logic [2:0] bit_pos);
    logic [7:0] t;
    case (bit_pos)
      3'd0:    t = 8'h5E;
      3'd1:    t = 8'hBC;
      3'd2:    t = 8'h61;
      3'd3:    t = 8'hC2;
      3'd4:    t = 8'h9D;
      3'd5:    t = 8'h23;
      3'd6:    t = 8'h46;
      3'd7:    t = 8'h8C;
      default: t = 8'h00;
    endcase
    return t;
  endfunction

  // one byte of reflected crc-8, poly 0x8c
  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] x;
    logic [7:0] r;
    x = crc ^ data;
    r = 8'h00;
    for (int b = 0; b < 8; b++) begin
      if (x[b]) begin
        r = r ^ crc_term(3'(b));
      end
    end
    return r;
  endfunction

endpackage

### hdl/wtel_if.sv
// word channels for the wind telemetry framer
interface wtel_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] direction;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output direction, output rx_byte,
                  input ready);
  modport sink (input valid, input operation, input direction, input rx_byte,
                output ready);
endinterface

interface wtel_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, output kind, output tx_byte, output last, input ready);
  modport sink (input valid, input kind, input tx_byte, input last, output ready);
endinterface

### hdl/wind_telemetry_framer.sv
// wind telemetry framer: second slots, frame build with crc-8, reply watch, error budget
//
// Pulses, received bytes and ticks that do not close a frame give no result,
// but a ring, or a slot-two tick that runs the error budget out, gives one
// reset request word. The tick that wraps the slot counter gives a frame of
// SAMPLES_PER_FRAME + 4 words (9 here): a small sequencer walks the frame
// bytes through one shared crc-8 byte unit, loading one word a cycle into the
// output register while the sink takes them, and input ready stays low until
// the crc word is loaded. Words go out through a single output register; a new
// item can be taken while the last word still waits there. The error_limit
// write takes effect at the next budget refill or reinitialisation.
module wind_telemetry_framer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  wtel_in_if.sink            in_if,
  wtel_out_if.source         out_if
);
  import wtel_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EMIT = 3'b010,
    ST_REQ  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [7:0]           error_limit_r;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [15:0]          uptime_r, uptime_nxt;
  logic [7:0]           pulse_r, pulse_nxt;
  logic [7:0]           dir_r [SAMPLES_PER_FRAME];
  logic [7:0]           dir_nxt [SAMPLES_PER_FRAME];
  logic [MATCH_W-1:0]   match_r, match_nxt;
  logic                 seen_r, seen_nxt;
  logic                 listen_r, listen_nxt;
  logic [7:0]           errors_r, errors_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [7:0]           crc_r, crc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 accept;
  logic                 load_ok;
  logic [SLOT_W:0]      slot_inc;
  logic [SLOT_W-1:0]    slot_new;
  logic                 wrap;
  logic [IDX_W-1:0]     dir_idx;
  logic [7:0]           emit_byte;
  logic [7:0]           errors_dec;

  assign in_if.ready    = (state_r == ST_IDLE);
  assign accept         = in_if.valid && in_if.ready;
  assign load_ok        = !out_valid_r || out_if.ready;

  assign out_if.valid   = out_valid_r;
  assign out_if.kind    = out_kind_r;
  assign out_if.tx_byte = out_byte_r;
  assign out_if.last    = out_last_r;

  assign slot_inc   = {1'b0, slot_r} + (SLOT_W+1)'(1);
  assign wrap       = (slot_inc >= (SLOT_W+1)'(SAMPLES_PER_FRAME));
  assign slot_new   = wrap ? '0 : slot_inc[SLOT_W-1:0];
  assign dir_idx    = idx_r - IDX_W'(HDR_LEN);
  assign errors_dec = errors_r - 8'd1;

  // frame byte mux feeding the output register and the crc unit
  always_comb begin
    if (idx_r == IDX_UP_HI) begin
      emit_byte = uptime_r[15:8];
    end else if (idx_r == IDX_UP_LO) begin
      emit_byte = uptime_r[7:0];
    end else if (idx_r == IDX_PULSE) begin
      emit_byte = pulse_r;
    end else if (idx_r == IDX_CRC) begin
      emit_byte = crc_r;
    end else begin
      emit_byte = dir_r[dir_idx[SLOT_W-1:0]];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    uptime_nxt    = uptime_r;
    pulse_nxt     = pulse_r;
    dir_nxt       = dir_r;
    match_nxt     = match_r;
    seen_nxt      = seen_r;
    listen_nxt    = listen_r;
    errors_nxt    = errors_r;
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(in_if.operation))
            OP_PULSE: begin
              pulse_nxt = pulse_r + 8'd1;
            end
            OP_RING: begin
              state_nxt = ST_REQ;
            end
            OP_RX: begin
              if (listen_r) begin
                if (match_r < MATCH_W'(REPLY_LEN) && in_if.rx_byte == reply_byte(match_r)) begin
                  if (match_r == MATCH_W'(REPLY_LEN - 1)) begin
                    seen_nxt   = 1'b1;
                    match_nxt  = '0;
                    listen_nxt = 1'b0;
                  end else begin
                    match_nxt = match_r + MATCH_W'(1);
                  end
                end else begin
                  seen_nxt   = 1'b0;
                  match_nxt  = '0;
                  listen_nxt = 1'b0;
                end
              end
            end
            OP_TICK: begin
              slot_nxt          = slot_new;
              dir_nxt[slot_new] = in_if.direction;
              if (wrap) begin
                uptime_nxt = uptime_r + 16'd1;
                match_nxt  = '0;
                seen_nxt   = 1'b0;
                listen_nxt = 1'b1;
                idx_nxt    = '0;
                crc_nxt    = 8'h00;
                state_nxt  = ST_EMIT;
              end else if (slot_new == SLOT_W'(2)) begin
                listen_nxt = 1'b0;
                if (seen_r) begin
                  errors_nxt = error_limit_r;
                end else begin
                  errors_nxt = errors_dec;
                  if (errors_dec == 8'd0) begin
                    state_nxt = ST_REQ;
                  end
                end
              end
            end
            default: begin
              state_nxt = state_r;
            end
          endcase
          // reinitialise at once, the request word follows
          if (state_nxt == ST_REQ) begin
            slot_nxt   = '0;
            uptime_nxt = '0;
            pulse_nxt  = '0;
            for (int i = 0; i < SAMPLES_PER_FRAME; i++) begin
              dir_nxt[i] = 8'h00;
            end
            match_nxt  = '0;
            seen_nxt   = 1'b0;
            listen_nxt = 1'b0;
            errors_nxt = error_limit_r;
          end
        end
      end
      ST_EMIT: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FRAME;
          out_byte_nxt  = emit_byte;
          out_last_nxt  = (idx_r == IDX_CRC);
          crc_nxt       = crc_update(crc_r, emit_byte);
          idx_nxt       = idx_r + IDX_W'(1);
          if (idx_r == IDX_PULSE) begin
            pulse_nxt = 8'h00;
          end
          if (idx_r == IDX_CRC) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_REQ: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_RESET;
          out_byte_nxt  = 8'h00;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      error_limit_r <= ERROR_LIMIT_RST;
      slot_r        <= '0;
      uptime_r      <= '0;
      pulse_r       <= '0;
      for (int i = 0; i < SAMPLES_PER_FRAME; i++) begin
        dir_r[i] <= 8'h00;
      end
      match_r       <= '0;
      seen_r        <= 1'b0;
      listen_r      <= 1'b0;
      errors_r      <= ERROR_LIMIT_RST;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_wr_en) begin
        error_limit_r <= cfg_wr_data;
      end
      slot_r        <= slot_nxt;
      uptime_r      <= uptime_nxt;
      pulse_r       <= pulse_nxt;
      dir_r         <= dir_nxt;
      match_r       <= match_nxt;
      seen_r        <= seen_nxt;
      listen_r      <= listen_nxt;
      errors_r      <= errors_nxt;
      idx_r         <= idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r      <= crc_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  a_req_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.kind == KIND_RESET |-> out_if.last && out_if.tx_byte == 8'h00)
    else $error("reset request word malformed");

  a_ring_to_req: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_if.operation == OP_RING |=> state_r == ST_REQ && slot_r == '0)
    else $error("ring did not lead to a reset request");

  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && !(load_ok && idx_r == IDX_CRC) |=> state_r == ST_EMIT && !in_if.ready)
    else $error("frame sequencer left early");

  a_frame_starts_listen: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_if.operation == OP_TICK && wrap |=> state_r == ST_EMIT && listen_r
    && idx_r == '0)
    else $error("frame tick did not open the reply watch");

endmodule
